@@ rtl/sdpd_pkg.sv @@
// Shared types, codes and lookup functions for the SMS-DELIVER PDU stream decoder.
`timescale 1ns / 1ps
`default_nettype none
package sdpd_pkg;

  localparam logic [1:0] KIND_ADDR = 2'd0;
  localparam logic [1:0] KIND_MSG  = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] TOA_INTL = 8'h91;
  localparam int unsigned PREFIX_LEN = 5;
  localparam int unsigned SCTS_LEN   = 7;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    PH_SC_LEN    = 4'd0,
    PH_SC_SKIP   = 4'd1,
    PH_TYPE      = 4'd2,
    PH_OA_LEN    = 4'd3,
    PH_OA_TYPE   = 4'd4,
    PH_OA_DIGITS = 4'd5,
    PH_PID       = 4'd6,
    PH_DCS       = 4'd7,
    PH_SCTS      = 4'd8,
    PH_UDL       = 4'd9,
    PH_UD        = 4'd10,
    PH_DONE      = 4'd11
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] ch;
    logic       last;
  } res_word_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_word_t  w0;
    res_word_t  w1;
  } push_t;

  typedef struct packed {
    logic [QCW-1:0] fill;
  } q_stat_t;

  // "+CMT:" notification prefix
  function automatic logic [7:0] cmt_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h2B;
      3'd1:    c = 8'h43;
      3'd2:    c = 8'h4D;
      3'd3:    c = 8'h54;
      3'd4:    c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // bad digits decode as 0xFF
  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39)      v = c - 8'h30;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    else                               v = 8'hFF;
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/sdpd_core.sv @@
// Line framing, hex pairing, PDU field decode; one received word per take cycle.
`timescale 1ns / 1ps
`default_nettype none
module sdpd_core
  import sdpd_pkg::*;
#(
  parameter int unsigned MAX_LINE = 511
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       take,
  input  wire logic [7:0] rx_byte,
  output push_t           push
);

  localparam int unsigned LCW = $clog2(MAX_LINE + 1);
  localparam logic [LCW-1:0] LINE_LIM = LCW'(MAX_LINE);
  localparam logic [LCW-1:0] PFX_LEN  = LCW'(PREFIX_LEN);

  logic           pdu_mode_r,  pdu_mode_nxt;
  logic [LCW-1:0] line_cnt_r,  line_cnt_nxt;
  logic           prefix_ok_r, prefix_ok_nxt;
  logic           hex_half_r,  hex_half_nxt;
  logic [3:0]     hi_nib_r,    hi_nib_nxt;
  phase_t         phase_r,     phase_nxt;
  logic [7:0]     skip_r,      skip_nxt;
  logic [7:0]     digits_r,    digits_nxt;
  logic [6:0]     carry_r,     carry_nxt;
  logic [2:0]     ccnt_r,      ccnt_nxt;
  logic [7:0]     septs_r,     septs_nxt;

  logic [7:0]  nib;
  logic [7:0]  pbyte;
  logic [2:0]  ucnt;
  logic [14:0] ushift;
  logic [7:0]  uhigh;
  logic [6:0]  sept0;
  logic [6:0]  sept1;
  logic [1:0]  n;
  res_word_t   w0, w1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pdu_mode_r  <= 1'b0;
      line_cnt_r  <= '0;
      prefix_ok_r <= 1'b1;
      hex_half_r  <= 1'b0;
      hi_nib_r    <= '0;
      phase_r     <= PH_SC_LEN;
      skip_r      <= '0;
      digits_r    <= '0;
      carry_r     <= '0;
      ccnt_r      <= '0;
      septs_r     <= '0;
    end else if (take) begin
      pdu_mode_r  <= pdu_mode_nxt;
      line_cnt_r  <= line_cnt_nxt;
      prefix_ok_r <= prefix_ok_nxt;
      hex_half_r  <= hex_half_nxt;
      hi_nib_r    <= hi_nib_nxt;
      phase_r     <= phase_nxt;
      skip_r      <= skip_nxt;
      digits_r    <= digits_nxt;
      carry_r     <= carry_nxt;
      ccnt_r      <= ccnt_nxt;
      septs_r     <= septs_nxt;
    end
  end

  assign nib    = hex_value(rx_byte);
  assign pbyte  = {hi_nib_r, 4'h0} | nib;
  assign ucnt   = (ccnt_r == 3'd7) ? 3'd6 : ccnt_r;
  assign ushift = {7'd0, pbyte} << ucnt;
  assign uhigh  = pbyte >> (3'd7 - ucnt);
  assign sept0  = ushift[6:0] | carry_r;
  assign sept1  = uhigh[6:0];

  always_comb begin
    pdu_mode_nxt  = pdu_mode_r;
    line_cnt_nxt  = line_cnt_r;
    prefix_ok_nxt = prefix_ok_r;
    hex_half_nxt  = hex_half_r;
    hi_nib_nxt    = hi_nib_r;
    phase_nxt     = phase_r;
    skip_nxt      = skip_r;
    digits_nxt    = digits_r;
    carry_nxt     = carry_r;
    ccnt_nxt      = ccnt_r;
    septs_nxt     = septs_r;
    n  = 2'd0;
    w0 = '0;
    w1 = '0;

    if (rx_byte == CH_CR) begin
      // dropped
    end else if (rx_byte == CH_LF) begin
      if (pdu_mode_r) begin
        w0 = '{kind: KIND_END, ch: 7'd0, last: 1'b0};
        n  = 2'd1;
        pdu_mode_nxt = 1'b0;
      end else if (prefix_ok_r && line_cnt_r >= PFX_LEN) begin
        pdu_mode_nxt = 1'b1;
        hi_nib_nxt   = '0;
        phase_nxt    = PH_SC_LEN;
        skip_nxt     = '0;
        digits_nxt   = '0;
        carry_nxt    = '0;
        ccnt_nxt     = '0;
        septs_nxt    = '0;
      end
      line_cnt_nxt  = '0;
      prefix_ok_nxt = 1'b1;
      hex_half_nxt  = 1'b0;
    end else if (line_cnt_r < LINE_LIM) begin
      line_cnt_nxt = line_cnt_r + LCW'(1);
      if (pdu_mode_r) begin
        if (phase_r != PH_DONE) begin
          if (rx_byte == 8'h00) begin
            phase_nxt = PH_DONE;
          end else if (!hex_half_r) begin
            hi_nib_nxt   = nib[3:0];
            hex_half_nxt = 1'b1;
          end else begin
            hex_half_nxt = 1'b0;
            unique case (phase_r)
              PH_SC_LEN: begin
                skip_nxt  = pbyte;
                phase_nxt = (pbyte == 8'd0) ? PH_TYPE : PH_SC_SKIP;
              end
              PH_SC_SKIP: begin
                skip_nxt = skip_r - 8'd1;
                if (skip_r == 8'd1) phase_nxt = PH_TYPE;
              end
              PH_TYPE:   phase_nxt = PH_OA_LEN;
              PH_OA_LEN: begin
                digits_nxt = pbyte;
                phase_nxt  = PH_OA_TYPE;
              end
              PH_OA_TYPE: begin
                if (pbyte == TOA_INTL) begin
                  w0 = '{kind: KIND_ADDR, ch: CH_PLUS[6:0], last: 1'b0};
                  n  = 2'd1;
                end
                phase_nxt = (digits_r == 8'd0) ? PH_PID : PH_OA_DIGITS;
              end
              PH_OA_DIGITS: begin
                // low nibble is the first digit of the pair
                if (digits_r != 8'd0) begin
                  w0 = '{kind: KIND_ADDR, ch: 7'({3'd0, pbyte[3:0]} + CH_ZERO[6:0]),
                         last: 1'b0};
                  n  = 2'd1;
                end
                if (digits_r >= 8'd2) begin
                  w1 = '{kind: KIND_ADDR, ch: 7'({3'd0, pbyte[7:4]} + CH_ZERO[6:0]),
                         last: 1'b0};
                  n  = 2'd2;
                end
                digits_nxt = (digits_r >= 8'd2) ? digits_r - 8'd2 : 8'd0;
                if (digits_r <= 8'd2) phase_nxt = PH_PID;
              end
              PH_PID: phase_nxt = PH_DCS;
              PH_DCS: begin
                skip_nxt  = 8'(SCTS_LEN);
                phase_nxt = PH_SCTS;
              end
              PH_SCTS: begin
                skip_nxt = skip_r - 8'd1;
                if (skip_r == 8'd1) phase_nxt = PH_UDL;
              end
              PH_UDL: begin
                septs_nxt = pbyte;
                carry_nxt = '0;
                ccnt_nxt  = '0;
                phase_nxt = PH_UD;
              end
              PH_UD: begin
                septs_nxt = septs_r;
                if (septs_r != 8'd0) begin
                  w0 = '{kind: KIND_MSG, ch: sept0, last: 1'b0};
                  n  = 2'd1;
                  septs_nxt = septs_r - 8'd1;
                end
                // every seventh byte completes an extra septet from the carry
                if (ucnt == 3'd6) begin
                  if (septs_nxt != 8'd0) begin
                    if (n == 2'd0) begin
                      w0 = '{kind: KIND_MSG, ch: sept1, last: 1'b0};
                      n  = 2'd1;
                    end else begin
                      w1 = '{kind: KIND_MSG, ch: sept1, last: 1'b0};
                      n  = 2'd2;
                    end
                    septs_nxt = septs_nxt - 8'd1;
                  end
                  carry_nxt = '0;
                  ccnt_nxt  = '0;
                end else begin
                  carry_nxt = sept1;
                  ccnt_nxt  = ucnt + 3'd1;
                end
              end
              default: phase_nxt = PH_DONE;
            endcase
          end
        end
      end else if (line_cnt_r < PFX_LEN) begin
        if (rx_byte != cmt_char(line_cnt_r[2:0])) prefix_ok_nxt = 1'b0;
      end
    end

    w0.last = (n == 2'd1);
    w1.last = 1'b1;
  end

  assign push.cnt = take ? n : 2'd0;
  assign push.w0  = w0;
  assign push.w1  = w1;

endmodule
`default_nettype wire

@@ rtl/sdpd_resq.sv @@
// Result queue: takes up to two words per cycle, hands out one per pop.
`timescale 1ns / 1ps
`default_nettype none
module sdpd_resq
  import sdpd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  input  wire logic  pop,
  output res_word_t  head,
  output q_stat_t    stat
);

  res_word_t      mem [QDEPTH];
  logic [QPW-1:0] wr_r, wr_nxt;
  logic [QPW-1:0] rd_r, rd_nxt;
  logic [QCW-1:0] fill_r, fill_nxt;

  assign wr_nxt   = wr_r + QPW'(push.cnt);
  assign rd_nxt   = rd_r + QPW'(pop);
  assign fill_nxt = fill_r + QCW'(push.cnt) - QCW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      fill_r <= '0;
    end else begin
      wr_r   <= wr_nxt;
      rd_r   <= rd_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem[wr_r] <= push.w0;
    if (push.cnt == 2'd2) mem[wr_r + QPW'(1)] <= push.w1;
  end

  assign head      = mem[rd_r];
  assign stat.fill = fill_r;

endmodule
`default_nettype wire

@@ rtl/sms_deliver_pdu_stream_decoder.sv @@
// Top level: received-character decoder for SMS-DELIVER PDUs with a result queue.
// Results of an accepted word are queued and go out on out_ after older words.
// Throughput: one input word per cycle while the four-word result queue has two free
//   slots; out_ drains one word per ready cycle, so two-result words set the pace.
// Reset (synchronous, rst_n low) empties the queue, disarms the decoder and clears
//   the line state.
`timescale 1ns / 1ps
`default_nettype none
module sms_deliver_pdu_stream_decoder
  import sdpd_pkg::*;
#(
  parameter int unsigned MAX_LINE = 511
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_kind,
  output logic [6:0]      out_char_value,
  output logic            out_last_of_run
);

  push_t     push;
  res_word_t head;
  q_stat_t   stat;
  logic      take;
  logic      pop;

  assign in_ready  = (stat.fill <= QCW'(QDEPTH - 2));
  assign take      = in_valid && in_ready;
  assign out_valid = (stat.fill != '0);
  assign pop       = out_valid && out_ready;

  sdpd_core #(.MAX_LINE(MAX_LINE)) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_rx_byte),
    .push    (push)
  );

  sdpd_resq u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .stat  (stat)
  );

  assign out_kind        = head.kind;
  assign out_char_value  = head.ch;
  assign out_last_of_run = head.last;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.fill <= QCW'(QDEPTH))
    else $error("result queue overfilled");

  a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> stat.fill ==
      QCW'($past(stat.fill) + QCW'($past(push.cnt)) - QCW'($past(pop))))
    else $error("queue fill does not track pushes and pops");

  a_end_single: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0 && push.w0.kind == KIND_END) |-> push.cnt == 2'd1)
    else $error("end marker shares a word run");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_END) |-> out_last_of_run)
    else $error("end marker not flagged last");

endmodule
`default_nettype wire

@@ tb/sv/sdpd_char_checker.sv @@
// Checker for the PDU stream decoder: predicts output words from accepted input words.
`timescale 1ns / 1ps
module sdpd_char_checker
  import sdpd_pkg::*;
#(
  parameter int unsigned MAX_LINE = 511
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic [1:0] out_kind,
  input  wire logic [6:0] out_char_value,
  input  wire logic       out_last_of_run,
  output logic [31:0]     fail_count,
  output logic [31:0]     pending
);

  localparam logic [39:0] NOTIFY_TAG   = "+CMT:";
  localparam int          REPORT_LIMIT = 10;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] value;
    logic       last;
  } char_word_t;

  char_word_t expected_chars[$];
  char_word_t w0, w1, want;
  int         step_n;
  int         errors;

  // decoder state as the predictor sees it
  logic       armed;
  int         line_len;
  logic       tag_match;
  logic       half_pending;
  logic [7:0] hi_nib;
  phase_t     phase;
  logic [7:0] skip_cnt;
  logic [7:0] digits_cnt;
  logic [7:0] sept_cnt;
  logic [6:0] sept_carry;
  logic [2:0] carry_fill;

  task automatic start_pdu();
    half_pending = 1'b0;
    hi_nib       = 8'h00;
    phase        = PH_SC_LEN;
    skip_cnt     = 8'd0;
    digits_cnt   = 8'd0;
    sept_carry   = 7'd0;
    carry_fill   = 3'd0;
    sept_cnt     = 8'd0;
  endtask

  task automatic reset_predictor();
    armed     = 1'b0;
    line_len  = 0;
    tag_match = 1'b1;
    start_pdu();
  endtask

  task automatic emit_char(input logic [1:0] kind, input logic [6:0] value);
    if (step_n == 0) begin
      w0 = {kind, value, 1'b0};
    end else if (step_n == 1) begin
      w1 = {kind, value, 1'b0};
    end
    if (step_n < 2) step_n++;
  endtask

  task automatic take_septet(input logic [6:0] value);
    if (sept_cnt != 8'd0) begin
      emit_char(KIND_MSG, value);
      sept_cnt--;
    end
  endtask

  function automatic logic [7:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'hFF;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    if (c >= 8'h41 && c <= 8'h46) v = c - 8'h41 + 8'd10;
    if (c >= 8'h61 && c <= 8'h66) v = c - 8'h61 + 8'd10;
    return v;
  endfunction

  task automatic advance_pdu(input logic [7:0] b);
    int          cnt;
    logic [15:0] wide;
    logic [7:0]  spill;
    case (phase)
      PH_SC_LEN: begin
        skip_cnt = b;
        if (b == 8'd0) phase = PH_TYPE;
        else phase = PH_SC_SKIP;
      end
      PH_SC_SKIP: begin
        skip_cnt--;
        if (skip_cnt == 8'd0) phase = PH_TYPE;
      end
      PH_TYPE: phase = PH_OA_LEN;
      PH_OA_LEN: begin
        digits_cnt = b;
        phase = PH_OA_TYPE;
      end
      PH_OA_TYPE: begin
        if (b == TOA_INTL) emit_char(KIND_ADDR, CH_PLUS[6:0]);
        if (digits_cnt == 8'd0) phase = PH_PID;
        else phase = PH_OA_DIGITS;
      end
      PH_OA_DIGITS: begin
        // low nibble first; digit + '0' keeps 3'b011 on top
        if (digits_cnt != 8'd0) begin
          emit_char(KIND_ADDR, {3'b011, b[3:0]});
          digits_cnt--;
        end
        if (digits_cnt != 8'd0) begin
          emit_char(KIND_ADDR, {3'b011, b[7:4]});
          digits_cnt--;
        end
        if (digits_cnt == 8'd0) phase = PH_PID;
      end
      PH_PID: phase = PH_DCS;
      PH_DCS: begin
        skip_cnt = 8'(SCTS_LEN);
        phase = PH_SCTS;
      end
      PH_SCTS: begin
        skip_cnt--;
        if (skip_cnt == 8'd0) phase = PH_UDL;
      end
      PH_UDL: begin
        sept_cnt   = b;
        sept_carry = 7'd0;
        carry_fill = 3'd0;
        phase      = PH_UD;
      end
      PH_UD: begin
        cnt = (carry_fill > 3'd6) ? 6 : carry_fill;
        wide = ({8'h00, b} << cnt) | {9'h000, sept_carry};
        take_septet(wide[6:0]);
        spill = b >> (7 - cnt);
        sept_carry = spill[6:0];
        cnt++;
        // every seventh byte completes a whole extra septet
        if (cnt == 7) begin
          take_septet(sept_carry);
          sept_carry = 7'd0;
          cnt = 0;
        end
        carry_fill = cnt[2:0];
      end
      default: phase = PH_DONE;
    endcase
  endtask

  task automatic decode_rx_byte(input logic [7:0] c);
    logic [7:0] nib;
    step_n = 0;
    if (c != CH_CR) begin
      if (c == CH_LF) begin
        if (armed) begin
          emit_char(KIND_END, 7'd0);
          armed = 1'b0;
        end else if (tag_match && line_len >= PREFIX_LEN) begin
          armed = 1'b1;
          start_pdu();
        end
        line_len     = 0;
        tag_match    = 1'b1;
        half_pending = 1'b0;
      end else if (line_len < MAX_LINE) begin
        if (armed) begin
          if (phase != PH_DONE) begin
            if (c == 8'h00) begin
              phase = PH_DONE;
            end else begin
              nib = nibble_of(c);
              if (!half_pending) begin
                hi_nib = nib;
                half_pending = 1'b1;
              end else begin
                half_pending = 1'b0;
                advance_pdu({hi_nib[3:0], 4'h0} | nib);
              end
            end
          end
        end else if (line_len < PREFIX_LEN) begin
          if (c != NOTIFY_TAG[39 - 8*line_len -: 8]) tag_match = 1'b0;
        end
        line_len++;
      end
      if (step_n == 1) begin
        w0.last = 1'b1;
        expected_chars.push_back(w0);
      end else if (step_n == 2) begin
        expected_chars.push_back(w0);
        w1.last = 1'b1;
        expected_chars.push_back(w1);
      end
    end
  endtask

  initial begin
    errors = 0;
    reset_predictor();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_predictor();
      expected_chars.delete();
    end else begin
      // outputs first: a word accepted now never belongs to this edge's input
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          if (errors < REPORT_LIMIT)
            $display("%0t: unexpected output word kind=%0d char=%02h last=%0b",
                     $time, out_kind, out_char_value, out_last_of_run);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (out_kind !== want.kind || out_char_value !== want.value ||
              out_last_of_run !== want.last) begin
            if (errors < REPORT_LIMIT)
              $display({"%0t: output mismatch: expected kind=%0d char=%02h last=%0b,",
                        " got kind=%0d char=%02h last=%0b"},
                       $time, want.kind, want.value, want.last,
                       out_kind, out_char_value, out_last_of_run);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) decode_rx_byte(in_rx_byte);
    end
    pending    <= expected_chars.size();
    fail_count <= errors;
  end

endmodule

@@ tb/sv/sms_deliver_pdu_stream_decoder_tb.sv @@
// Testbench top: feeds modem character streams to the PDU decoder and reports the verdict.
`timescale 1ns / 1ps
module sms_deliver_pdu_stream_decoder_tb;
  import sdpd_pkg::*;

  localparam int unsigned MAX_LINE       = 511;
  localparam int          ITEM_TARGET    = 1950;
  localparam int          WATCHDOG_LIMIT = 2000;
  // characters just outside the hex digit ranges: / : @ G backquote g
  localparam logic [47:0] HEX_EDGES      = {8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_ready  = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [6:0]  out_char_value;
  logic        out_last_of_run;
  logic [31:0] fail_count;
  logic [31:0] pending;

  logic [7:0] text_q[$];
  logic [7:0] pdu_q[$];
  int         sent_items = 0;
  int         line_pos   = 0;
  int         burst_left = 0;
  int         ready_left = 0;
  bit         steady     = 1'b0;

  always #1 clk = ~clk;

  sms_deliver_pdu_stream_decoder #(
    .MAX_LINE(MAX_LINE)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_char_value (out_char_value),
    .out_last_of_run(out_last_of_run)
  );

  sdpd_char_checker #(
    .MAX_LINE(MAX_LINE)
  ) char_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_char_value (out_char_value),
    .out_last_of_run(out_last_of_run),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // receiver: runs of ready and stalls, always ready in steady stretches
  always @(posedge clk) begin
    if (steady) begin
      out_ready <= 1'b1;
      ready_left = 0;
    end else if (ready_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        ready_left = $urandom_range(1, 30);
      end else begin
        out_ready <= 1'b0;
        ready_left = $urandom_range(1, 12);
      end
    end else begin
      ready_left--;
    end
  end

  task automatic send_char(input logic [7:0] b);
    if (!steady && burst_left == 0) begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(5, 24)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    if (burst_left > 0) burst_left--;
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // CRs and characters past the line limit do nothing, so they are not counted
    if (b == CH_LF) begin
      line_pos = 0;
      sent_items++;
    end else if (b != CH_CR) begin
      if (line_pos < MAX_LINE) sent_items++;
      line_pos++;
    end
  endtask

  task automatic flush_line();
    int i;
    for (i = 0; i < text_q.size(); i++) send_char(text_q[i]);
    text_q.delete();
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic add_eol();
    if ($urandom_range(0, 1)) text_q.push_back(CH_CR);
    text_q.push_back(CH_LF);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + nib;
    else if ($urandom_range(0, 1)) return 8'h61 + nib - 8'd10;
    else return 8'h41 + nib - 8'd10;
  endfunction

  task automatic add_hex(input logic [7:0] b);
    text_q.push_back(hex_char(b[7:4]));
    text_q.push_back(hex_char(b[3:0]));
  endtask

  // notification line plus PDU line; corrupt < 0 leaves the PDU text intact
  task automatic sms_message(input bit bad_header, input int corrupt, input bit overlong);
    int         sc_len;
    int         n_digits;
    int         udl;
    int         pos;
    int         i;
    logic [7:0] b;
    logic [3:0] lo;
    logic [3:0] hi;
    text_q.delete();
    add_text("+CMT:");
    if (bad_header) begin
      if ($urandom_range(0, 1)) begin
        pos = $urandom_range(0, 4);
        text_q[pos] = text_q[pos] ^ (8'h01 << $urandom_range(0, 7));
      end else begin
        pos = $urandom_range(0, 4);
        while (text_q.size() > pos) b = text_q.pop_back();
      end
    end
    if (text_q.size() == 5)
      repeat ($urandom_range(0, 10)) begin
        b = 8'($urandom_range(32, 126));
        text_q.push_back(b);
      end
    add_eol();
    flush_line();

    pdu_q.delete();
    sc_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
    b = 8'(sc_len);
    pdu_q.push_back(b);
    repeat (sc_len) begin
      b = 8'($urandom);
      pdu_q.push_back(b);
    end
    b = 8'($urandom);
    pdu_q.push_back(b);
    n_digits = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 14);
    if ($urandom_range(0, 19) == 0) n_digits = $urandom_range(15, 40);
    b = 8'(n_digits);
    pdu_q.push_back(b);
    b = $urandom_range(0, 1) ? TOA_INTL : 8'($urandom);
    pdu_q.push_back(b);
    for (i = 0; i < (n_digits + 1) / 2; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        b = 8'($urandom);
      end else begin
        lo = 4'($urandom_range(0, 9));
        hi = 4'($urandom_range(0, 9));
        b = {hi, lo};
      end
      if (n_digits % 2 == 1 && i == n_digits / 2) b[7:4] = 4'hF;
      pdu_q.push_back(b);
    end
    repeat (2 + SCTS_LEN) begin
      b = 8'($urandom);
      pdu_q.push_back(b);
    end
    if (overlong) udl = 255;
    else if ($urandom_range(0, 5) == 0) udl = 0;
    else if ($urandom_range(0, 9) == 0) udl = $urandom_range(100, 160);
    else udl = $urandom_range(1, 24);
    b = 8'(udl);
    pdu_q.push_back(b);
    repeat ((udl * 7 + 7) / 8) begin
      b = 8'($urandom);
      pdu_q.push_back(b);
    end

    text_q.delete();
    for (i = 0; i < pdu_q.size(); i++) add_hex(pdu_q[i]);
    if (overlong)
      while (text_q.size() < MAX_LINE + 24)
        text_q.push_back(hex_char(4'($urandom_range(0, 15))));

    pos = $urandom_range(0, text_q.size() - 1);
    case (corrupt)
      0: begin
        if ($urandom_range(0, 1)) begin
          b = HEX_EDGES[8*$urandom_range(0, 5) +: 8];
        end else begin
          do b = 8'($urandom);
          while (b == CH_LF || b == CH_CR || (b >= 8'h30 && b <= 8'h39) ||
                 (b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66));
        end
        text_q[pos] = b;
      end
      1: text_q[pos] = 8'h00;
      2: while (text_q.size() > pos) b = text_q.pop_back();
      3: b = text_q.pop_back();
      4: repeat ($urandom_range(1, 6)) text_q.push_back(hex_char(4'($urandom_range(0, 15))));
      5: text_q[pos] = CH_CR;
      default: ;
    endcase
    add_eol();
    flush_line();
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("sms_deliver_pdu_stream_decoder regression: fail");
    $finish;
  end

  initial begin : stimulus
    int         round;
    int         pick;
    int         n;
    logic [7:0] b;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // byte extremes on a plain line, then a notification with a short PDU line:
    // no service centre, bad low digit in the type, '+' address with digits
    // above 9, a trailing half byte and a NUL before the line feed
    text_q.push_back(8'hFF);
    text_q.push_back(8'h00);
    text_q.push_back(CH_LF);
    add_text("+CMT:");
    text_q.push_back(CH_CR);
    text_q.push_back(CH_LF);
    add_text("000G0391BAF");
    text_q.push_back(8'h00);
    text_q.push_back(CH_LF);
    flush_line();
    wait_drain();

    round = 0;
    while (sent_items < ITEM_TARGET) begin
      steady = ($urandom_range(0, 5) == 0);
      pick = $urandom_range(0, 19);
      if (round == 3) begin
        sms_message(1'b0, -1, 1'b1);
      end else if (pick < 3) begin
        n = $urandom_range(0, 24);
        repeat (n) begin
          b = 8'($urandom);
          text_q.push_back(b);
        end
        text_q.push_back(CH_LF);
        flush_line();
      end else if (pick < 5) begin
        sms_message(1'b1, $urandom_range(0, 5), 1'b0);
      end else begin
        // a bare notification first: the next one is then read as PDU text
        if (pick == 5) begin
          add_text("+CMT:");
          add_eol();
          flush_line();
        end
        sms_message(1'b0, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : -1, 1'b0);
      end
      if (round % 7 == 6) wait_drain();
      round++;
    end

    steady = 1'b0;
    wait_drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("sms_deliver_pdu_stream_decoder regression: pass");
    else
      $display("sms_deliver_pdu_stream_decoder regression: fail");
    $finish;
  end

endmodule
